// ----- src/msgint_pkg.sv -----
package msgint_pkg;

   localparam int unsigned ValueBits = 64;
   localparam int unsigned ValueBytes = ValueBits / 8;

   // status codes
   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_NOT_INT = 2'd1;
   localparam logic [1:0] STATUS_TOO_WIDE = 2'd2;

   // format bytes
   localparam logic [7:0] FMT_UINT8 = 8'hcc;
   localparam logic [7:0] FMT_UINT16 = 8'hcd;
   localparam logic [7:0] FMT_UINT32 = 8'hce;
   localparam logic [7:0] FMT_UINT64 = 8'hcf;
   localparam logic [7:0] FMT_INT8 = 8'hd0;
   localparam logic [7:0] FMT_INT16 = 8'hd1;
   localparam logic [7:0] FMT_INT32 = 8'hd2;
   localparam logic [7:0] FMT_INT64 = 8'hd3;
   localparam logic [7:0] POS_FIXINT_LIMIT = 8'd128;
   localparam logic [7:0] NEG_FIXINT_BASE = 8'd224;

   localparam logic [3:0] WIDTH_RESET = 4'd4;

   typedef struct packed {
      logic [3:0] bytes_left;
      logic [3:0] payload_len;
      logic signed_kind;
      logic [ValueBits-1:0] accumulator;
   } dec_state_type;

   typedef struct packed {
      logic valid;
      logic [ValueBits-1:0] value;
      logic is_signed_format;
      logic [1:0] status;
   } dec_result_type;

endpackage

// ----- src/msgpack_integer_decoder_unit.sv -----
// Channel   | Direction | Handshake        | Payload
// ----------+-----------+------------------+---------------------------------------
// req       | in        | req_valid/stall  | req_in_byte[7:0]
// rsp       | out       | rsp_valid/stall  | rsp_value[63:0], rsp_is_signed_format,
//           |           |                  | rsp_status[1:0]
// csr       | in        | csr_valid/ready  | csr_result_bytes[3:0]
//
// One byte per cycle sustained while the response is not stalled. A byte lands in the
// input register, then the step logic updates the decode state and fills the
// response register when the response slot is free or emptying. Payload bytes
// other than the last give no response. Synchronous reset sets the width to 4 and
// the decoder to expect a format byte. A stalled response holds the input
// register, which then stalls the request side; csr is always ready.
module msgpack_integer_decoder_unit
   import msgint_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic [7:0] req_in_byte,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [ValueBits-1:0] rsp_value,
   output logic rsp_is_signed_format,
   output logic [1:0] rsp_status,
   input logic csr_valid,
   output logic csr_ready,
   input logic [3:0] csr_result_bytes
);

   logic in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic [3:0] width_ff;
   dec_state_type state_ff;
   dec_state_type state_nxt;
   dec_result_type step_result;
   logic advance;
   logic req_take;

   // the input register moves on when the response slot is free or emptying
   assign advance = !rsp_valid || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign req_take = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign in_valid_in = req_take || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
      end else if (csr_valid && csr_ready) begin
         width_ff <= csr_result_bytes;
      end
   end

   msgint_step u_step (
      .in_byte(in_byte_ff),
      .result_bytes(width_ff),
      .state_cur(state_ff),
      .state_nxt(state_nxt),
      .result(step_result)
   );

   // decode state only moves when a byte is consumed
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (in_valid_ff && advance) begin
         state_ff <= state_nxt;
      end
   end

   msgint_out_reg u_out (
      .clock(clock),
      .reset(reset),
      .load(in_valid_ff && advance),
      .result(step_result),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .rsp_value(rsp_value),
      .rsp_is_signed_format(rsp_is_signed_format),
      .rsp_status(rsp_status)
   );

endmodule

// ----- src/msgint_step.sv -----
module msgint_step
   import msgint_pkg::*;
(
   input logic [7:0] in_byte,
   input logic [3:0] result_bytes,
   input dec_state_type state_cur,
   output dec_state_type state_nxt,
   output dec_result_type result
);

   logic [3:0] width;
   logic [ValueBits-1:0] acc_shift;
   logic [ValueBits-1:0] src;
   logic [3:0] len;
   logic sgn;
   logic top_bit;
   logic fill;
   logic [ValueBits-1:0] extended;
   logic is_fmt;
   logic fmt_signed;
   logic [3:0] fmt_len;

   // clamp configured width to 1..8
   always_comb begin
      if (result_bytes == 4'd0) begin
         width = 4'd1;
      end else if (result_bytes > 4'd8) begin
         width = 4'd8;
      end else begin
         width = result_bytes;
      end
   end

   assign acc_shift = {state_cur.accumulator[ValueBits-9:0], in_byte};

   // format byte lookup
   always_comb begin
      is_fmt = 1'b1;
      fmt_signed = 1'b0;
      fmt_len = 4'd1;
      unique case (in_byte)
         FMT_UINT8: fmt_len = 4'd1;
         FMT_UINT16: fmt_len = 4'd2;
         FMT_UINT32: fmt_len = 4'd4;
         FMT_UINT64: fmt_len = 4'd8;
         FMT_INT8: begin
            fmt_len = 4'd1;
            fmt_signed = 1'b1;
         end
         FMT_INT16: begin
            fmt_len = 4'd2;
            fmt_signed = 1'b1;
         end
         FMT_INT32: begin
            fmt_len = 4'd4;
            fmt_signed = 1'b1;
         end
         FMT_INT64: begin
            fmt_len = 4'd8;
            fmt_signed = 1'b1;
         end
         default: is_fmt = 1'b0;
      endcase
   end

   // source for the extender: collected payload or the fixint itself
   always_comb begin
      if (state_cur.bytes_left != 4'd0) begin
         src = acc_shift;
         len = state_cur.payload_len;
         sgn = state_cur.signed_kind;
      end else begin
         src = {{(ValueBits-8){1'b0}}, in_byte};
         len = 4'd1;
         sgn = (in_byte >= NEG_FIXINT_BASE);
      end
   end

   always_comb begin
      unique case (len)
         4'd1: top_bit = src[7];
         4'd2: top_bit = src[15];
         4'd4: top_bit = src[31];
         default: top_bit = src[ValueBits-1];
      endcase
   end

   assign fill = sgn && top_bit;

   // per byte: payload below len, sign fill up to width, zero above
   always_comb begin
      for (int i = 0; i < ValueBytes; i++) begin
         if (4'(i) >= width) begin
            extended[8*i +: 8] = 8'h00;
         end else if (4'(i) < len) begin
            extended[8*i +: 8] = src[8*i +: 8];
         end else begin
            extended[8*i +: 8] = {8{fill}};
         end
      end
   end

   always_comb begin
      state_nxt = state_cur;
      result.valid = 1'b0;
      result.value = '0;
      result.is_signed_format = 1'b0;
      result.status = STATUS_OK;
      if (state_cur.bytes_left != 4'd0) begin
         state_nxt.accumulator = acc_shift;
         state_nxt.bytes_left = state_cur.bytes_left - 4'd1;
         if (state_cur.bytes_left == 4'd1) begin
            result.valid = 1'b1;
            result.value = extended;
            result.is_signed_format = state_cur.signed_kind;
         end
      end else if (in_byte < POS_FIXINT_LIMIT) begin
         result.valid = 1'b1;
         result.value = {{(ValueBits-8){1'b0}}, in_byte};
      end else if (in_byte >= NEG_FIXINT_BASE) begin
         result.valid = 1'b1;
         result.value = extended;
         result.is_signed_format = 1'b1;
      end else if (!is_fmt) begin
         result.valid = 1'b1;
         result.status = STATUS_NOT_INT;
      end else if (fmt_len > width) begin
         result.valid = 1'b1;
         result.status = STATUS_TOO_WIDE;
         result.is_signed_format = fmt_signed;
      end else begin
         state_nxt.bytes_left = fmt_len;
         state_nxt.payload_len = fmt_len;
         state_nxt.signed_kind = fmt_signed;
         state_nxt.accumulator = '0;
      end
   end

endmodule

// ----- src/msgint_pkg_unused_guard.sv -----
module msgint_out_reg
   import msgint_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic load,
   input dec_result_type result,
   input logic rsp_stall,
   output logic rsp_valid,
   output logic [ValueBits-1:0] rsp_value,
   output logic rsp_is_signed_format,
   output logic [1:0] rsp_status
);

   logic valid_ff, valid_in;
   logic [ValueBits-1:0] value_ff;
   logic signed_ff;
   logic [1:0] status_ff;

   // load only happens when the slot is empty or being taken
   always_comb begin
      if (load) begin
         valid_in = result.valid;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && result.valid) begin
         value_ff <= result.value;
         signed_ff <= result.is_signed_format;
         status_ff <= result.status;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_value = value_ff;
   assign rsp_is_signed_format = signed_ff;
   assign rsp_status = status_ff;

endmodule
